### src/svd_pkg.sv
// Shared types and constants for the space vector PWM sector and duty block.
package svd_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int PER_W      = 15;
    localparam int PROD_W     = DATA_WIDTH + PER_W + 1;
    localparam int Q_W        = PER_W;
    localparam int NUM_W      = PROD_W - 1;
    localparam int REM_W      = DATA_WIDTH + 1;
    localparam int FRONT_ST   = 5;
    localparam int N_CELLS    = Q_W;
    localparam int N_STAGES   = FRONT_ST + N_CELLS + 1;

    localparam logic signed [DATA_WIDTH-1:0] K_ALPHA = 16'sd28378;

    localparam logic [2:0] SEC_NONE = 3'd0;
    localparam logic [2:0] SEC_1    = 3'd1;
    localparam logic [2:0] SEC_2    = 3'd2;
    localparam logic [2:0] SEC_3    = 3'd3;
    localparam logic [2:0] SEC_4    = 3'd4;
    localparam logic [2:0] SEC_5    = 3'd5;
    localparam logic [2:0] SEC_6    = 3'd6;
    localparam logic [2:0] SEC_ALL  = 3'd7;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] v_alpha;
        logic signed [DATA_WIDTH-1:0] v_beta;
    } in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] duty_u;
        logic signed [DATA_WIDTH-1:0] duty_v;
        logic signed [DATA_WIDTH-1:0] duty_w;
        logic [2:0]                   sector;
        logic                         overmodulated;
    } out_t;

    typedef struct packed {
        logic [2:0]                   sector;
        logic                         ovm;
        logic signed [DATA_WIDTH-1:0] t1;
        logic signed [DATA_WIDTH-1:0] t2;
        logic                         neg;
        logic [DATA_WIDTH-1:0]        den;
        logic [Q_W-1:0]               num;
        logic [REM_W-1:0]             rem;
        logic [Q_W-1:0]               quo;
    } div_t;

endpackage

### src/svd_front.sv
// Projections, sector decode, active times and overmodulation product stages.
module svd_front (
    input  logic                        aclk,
    input  logic [svd_pkg::FRONT_ST-1:0] en,
    input  svd_pkg::in_t                in_data,
    input  logic [svd_pkg::PER_W-1:0]   per,
    output svd_pkg::div_t               out_data
);
    import svd_pkg::*;

    logic signed [2*DATA_WIDTH-1:0] pa_prod_reg;
    logic signed [DATA_WIDTH-1:0]   vb_reg;
    logic signed [DATA_WIDTH-1:0]   r1_reg, r2_reg, r3_reg;
    logic [2:0]                     sec2_reg, sec3_reg, sec4_reg;
    logic signed [PROD_W-1:0]       p1_reg, p2_reg, p3_reg;
    logic signed [DATA_WIDTH-1:0]   t1_reg, t2_reg, sum_reg;
    logic                           ovm_reg;
    div_t                           out_reg;

    logic signed [DATA_WIDTH-1:0] pa, pb, r2_next, r3_next;
    logic [2:0]                   sec_next;
    logic signed [DATA_WIDTH-1:0] x, y, z, t1_next, t2_next, sum_next;
    logic signed [PROD_W-1:0]     per_s;
    logic signed [PROD_W-1:0]     tp;
    logic [PROD_W-1:0]            mag;
    div_t                         out_next;

    assign per_s = PROD_W'($signed({1'b0, per}));

    always_comb begin
        pa       = pa_prod_reg[DATA_WIDTH+14:15];
        pb       = {vb_reg[DATA_WIDTH-1], vb_reg[DATA_WIDTH-1:1]};
        r2_next  = pa - pb;
        r3_next  = -pa - pb;
        sec_next = {(r3_next > 0), (r2_next > 0), (vb_reg > 0)};
    end

    always_comb begin
        x = p1_reg[DATA_WIDTH+14:15];
        y = -p3_reg[DATA_WIDTH+14:15];
        z = -p2_reg[DATA_WIDTH+14:15];
        unique case (sec3_reg)
            SEC_1:   begin t1_next = z;  t2_next = y;  end
            SEC_2:   begin t1_next = y;  t2_next = -x; end
            SEC_3:   begin t1_next = -z; t2_next = x;  end
            SEC_4:   begin t1_next = -x; t2_next = z;  end
            SEC_5:   begin t1_next = x;  t2_next = -y; end
            SEC_6:   begin t1_next = -y; t2_next = -z; end
            default: begin t1_next = '0; t2_next = '0; end
        endcase
        sum_next = t1_next + t2_next;
    end

    always_comb begin
        tp  = PROD_W'(t1_reg) * per_s;
        mag = tp[PROD_W-1] ? -tp : tp;
        out_next.sector = sec4_reg;
        out_next.ovm    = ovm_reg;
        out_next.t1     = t1_reg;
        out_next.t2     = t2_reg;
        out_next.neg    = tp[PROD_W-1];
        out_next.den    = sum_reg;
        out_next.num    = mag[Q_W-1:0];
        out_next.rem    = REM_W'(mag[NUM_W-1:Q_W]);
        out_next.quo    = '0;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pa_prod_reg <= (2*DATA_WIDTH)'(in_data.v_alpha) * (2*DATA_WIDTH)'(K_ALPHA);
            vb_reg      <= in_data.v_beta;
        end
        if (en[1]) begin
            r1_reg   <= vb_reg;
            r2_reg   <= r2_next;
            r3_reg   <= r3_next;
            sec2_reg <= sec_next;
        end
        if (en[2]) begin
            p1_reg   <= PROD_W'(r1_reg) * per_s;
            p2_reg   <= PROD_W'(r2_reg) * per_s;
            p3_reg   <= PROD_W'(r3_reg) * per_s;
            sec3_reg <= sec2_reg;
        end
        if (en[3]) begin
            t1_reg   <= t1_next;
            t2_reg   <= t2_next;
            sum_reg  <= sum_next;
            ovm_reg  <= sum_next > $signed({1'b0, per});
            sec4_reg <= sec3_reg;
        end
        if (en[4]) begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

### src/svd_div_cell.sv
// One restoring-division cell: settles one quotient bit per stage.
module svd_div_cell (
    input  logic          aclk,
    input  logic          en,
    input  svd_pkg::div_t in_data,
    output svd_pkg::div_t out_data
);
    import svd_pkg::*;

    div_t             data_reg;
    div_t             data_next;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] den_x;
    logic             qbit;

    always_comb begin
        den_x     = REM_W'(in_data.den);
        trial     = {in_data.rem[REM_W-2:0], in_data.num[Q_W-1]};
        qbit      = trial >= den_x;
        data_next = in_data;
        data_next.rem = qbit ? trial - den_x : trial;
        data_next.num = {in_data.num[Q_W-2:0], 1'b0};
        data_next.quo = {in_data.quo[Q_W-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_data = data_reg;

endmodule

### src/svd_back.sv
// On-time centering, phase mapping and output register.
module svd_back (
    input  logic                      aclk,
    input  logic                      en,
    input  svd_pkg::div_t             in_data,
    input  logic [svd_pkg::PER_W-1:0] per,
    output svd_pkg::out_t             out_data
);
    import svd_pkg::*;

    out_t                         out_reg;
    out_t                         out_next;
    logic signed [DATA_WIDTH-1:0] per_s, q, t1, t2, diff, ta, tb, tc;

    always_comb begin
        per_s = DATA_WIDTH'($signed({1'b0, per}));
        q     = DATA_WIDTH'(in_data.quo);
        if (in_data.neg) begin
            q = -q;
        end
        t1 = in_data.ovm ? q : in_data.t1;
        t2 = in_data.ovm ? per_s - q : in_data.t2;
        diff = per_s - t1 - t2;
        ta   = diff >>> 1;
        tb   = ta + t1;
        tc   = tb + t2;
        out_next.sector        = in_data.sector;
        out_next.overmodulated = in_data.ovm;
        unique case (in_data.sector)
            SEC_1: begin
                out_next.duty_u = tb; out_next.duty_v = ta; out_next.duty_w = tc;
            end
            SEC_2: begin
                out_next.duty_u = ta; out_next.duty_v = tc; out_next.duty_w = tb;
            end
            SEC_3: begin
                out_next.duty_u = ta; out_next.duty_v = tb; out_next.duty_w = tc;
            end
            SEC_4: begin
                out_next.duty_u = tc; out_next.duty_v = tb; out_next.duty_w = ta;
            end
            SEC_5: begin
                out_next.duty_u = tc; out_next.duty_v = ta; out_next.duty_w = tb;
            end
            SEC_6: begin
                out_next.duty_u = tb; out_next.duty_v = tc; out_next.duty_w = ta;
            end
            default: begin
                out_next.duty_u = per_s; out_next.duty_v = per_s; out_next.duty_w = per_s;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

### src/svpwm_sector_duty.sv
// Top level: seven-segment space vector PWM sector and duty pipeline.
//
//  channel  | signals                        | carries
//  ---------+--------------------------------+------------------------------
//  s_       | s_valid, s_ready, s_data       | alpha/beta pair (in_t)
//  m_       | m_valid, m_ready, m_data       | duties, sector, flag (out_t)
//  cfg_     | cfg_we, cfg_wdata              | carrier period
//
// One item per cycle sustained while m_ready holds; 5 arithmetic stages,
// 15 one-bit divider cells for the overmodulation rescale, and an output register.
// Every stage advances on its own when its successor is empty or moving, so
// bubbles collapse and s_ready drops only when all stages hold items and
// the output is stalled. Reset clears the stage valids and loads period 3600.
module svpwm_sector_duty (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  svd_pkg::in_t              s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output svd_pkg::out_t             m_data,
    input  logic                      cfg_we,
    input  logic [svd_pkg::PER_W-1:0] cfg_wdata
);
    import svd_pkg::*;

    logic [PER_W-1:0]    per_reg;
    logic [N_STAGES-1:0] v_reg;
    logic [N_STAGES-1:0] v_next;
    logic [N_STAGES:0]   en;
    div_t                chain [N_CELLS+1];

    always_comb begin
        en[N_STAGES] = m_ready;
        for (int i = N_STAGES - 1; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? s_valid : v_reg[0];
        for (int i = 1; i < N_STAGES; i++) begin
            if (en[i]) begin
                v_next[i] = v_reg[i-1];
            end else begin
                v_next[i] = v_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg   <= '0;
            per_reg <= PER_W'(3600);
        end else begin
            v_reg <= v_next;
            if (cfg_we) begin
                per_reg <= cfg_wdata;
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[N_STAGES-1];

    svd_front u_front (
        .aclk     (aclk),
        .en       (en[FRONT_ST-1:0]),
        .in_data  (s_data),
        .per      (per_reg),
        .out_data (chain[0])
    );

    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        svd_div_cell u_cell (
            .aclk     (aclk),
            .en       (en[FRONT_ST+k]),
            .in_data  (chain[k]),
            .out_data (chain[k+1])
        );
    end

    svd_back u_back (
        .aclk     (aclk),
        .en       (en[N_STAGES-1]),
        .in_data  (chain[N_CELLS]),
        .per      (per_reg),
        .out_data (m_data)
    );

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while pipeline can move");

    a_ovm_sector: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.overmodulated) |->
            (m_data.sector != SEC_NONE && m_data.sector != SEC_ALL))
        else $error("overmodulation flagged in a null sector");

    a_null_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.sector == SEC_NONE || m_data.sector == SEC_ALL)) |->
            (m_data.duty_u == $signed({1'b0, per_reg}) &&
             m_data.duty_w == $signed({1'b0, per_reg})))
        else $error("null sector duty differs from period");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !v_reg[N_STAGES-2]) |=> !m_valid)
        else $error("output item repeated");

endmodule
